// ===== sv/hsda_pkg.sv =====
// shared types, constants and helpers for the hall speed duty adapter
package hsda_pkg;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 120;
    localparam int unsigned SPEED_W     = 32;
    localparam int unsigned TARGET_W    = 20;
    localparam int unsigned DUTY_W      = 17;
    localparam int unsigned PHASE_W     = 3;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned DIV_CNT_W   = 5;
    localparam int unsigned PROD_W      = SPEED_W + DUTY_W;

    localparam logic [DUTY_W-1:0] FULL_DUTY      = 17'd65536;
    localparam logic [DUTY_W-1:0] DUTY_START_RST = 17'd65536;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING = 3'd4;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_WAIT_A1_LOW  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RISE_A1      = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RISE_B1      = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT_A2_LOW  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_B2_LOW  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RISE_A2      = 3'd5;
    localparam logic [PHASE_W-1:0] PH_RISE_B2      = 3'd6;
    localparam logic [PHASE_W-1:0] PH_WAIT_REQ     = 3'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [DUTY_W-1:0] lim_duty(input logic [DUTY_W-1:0] v);
        lim_duty = (v > FULL_DUTY) ? FULL_DUTY : v;
    endfunction

endpackage

// ===== sv/hsda_divider.sv =====
// restoring divider, one quotient bit per cycle
module hsda_divider
    import hsda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SPEED_W-1:0] dividend,
    input  logic [SPEED_W-1:0] divisor,
    output logic [SPEED_W-1:0] quotient,
    output div_stat_t          stat
);

    logic [SPEED_W-1:0]   rem_reg, rem_next;
    logic [SPEED_W-1:0]   quo_reg, quo_next;
    logic [SPEED_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SPEED_W:0]     shifted;
    logic [SPEED_W:0]     diff;
    logic                 ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[SPEED_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[SPEED_W-1:0] : shifted[SPEED_W-1:0];
            quo_next = {quo_reg[SPEED_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(SPEED_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/hall_speed_duty_adapter_core.sv =====
// top level: hall period sequencer, speed average and proportional duty update
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+------------------------------------------
//  s_axis   | s_axis_tvalid/tready/tdata[7:0]  | hall_a1, hall_a2, adapt_request
//  m_axis   | m_axis_tvalid/tready/tdata[119:0]| duty, flags, speed, periods, phase
//  cfg      | cfg_we, cfg_index, cfg_data      | five registers at indexes 0 to 4, other indexes are ignored
//
// a plain tick passes through the load state into the output register
// a completing measurement adds two divides through the serial divider
// a duty update runs the 17 step shift-add multiplier
// one request is worked at a time; the next is taken while a result waits in the output register
// reset is asynchronous and loads duty with the default start value
module hall_speed_duty_adapter_core
    import hsda_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] hall_a1, [1] hall_a2, [2] adapt_request, [7:3] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [16:0] duty_q16, [17] duty_updated, [18] speed_valid, [50:19] wheel_speed_q16,
    // [82:51] period_first, [114:83] period_second, [117:115] seq_phase, [119:118] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SPEED_W-1:0]     cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV1  = 3'd1;
    localparam logic [2:0] S_DIV2  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ADAPT = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;

    localparam int unsigned ND_W = PROD_W - DUTY_W + 3;

    logic [SPEED_W-1:0]     speed_scale_reg;
    logic [TARGET_W-1:0]    target_speed_reg;
    logic [DUTY_W-1:0]      loop_gain_reg;
    logic [DUTY_W-1:0]      duty_floor_reg;
    logic [DUTY_W-1:0]      duty_ceiling_reg;

    logic [2:0]             state_reg, state_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [TIMER_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [DUTY_W-1:0]      duty_reg, duty_next;
    logic [SPEED_W-1:0]     last_speed_reg, last_speed_next;
    logic                   valid_flag_reg, valid_flag_next;
    logic                   upd_flag_reg, upd_flag_next;
    logic [DIV_CNT_W-1:0]   mul_cnt_reg, mul_cnt_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    logic [TIMER_BITS-1:0]  rise_a1_reg, rise_a1_next;
    logic [TIMER_BITS-1:0]  rise_b1_reg, rise_b1_next;
    logic [TIMER_BITS-1:0]  rise_a2_reg, rise_a2_next;
    logic [TIMER_BITS-1:0]  p1_reg, p1_next;
    logic [TIMER_BITS-1:0]  p2_reg, p2_next;
    logic [SPEED_W-1:0]     speed1_reg, speed1_next;
    logic [PROD_W-1:0]      mul_acc_reg, mul_acc_next;
    logic [SPEED_W-1:0]     mul_mag_reg, mul_mag_next;
    logic                   err_neg_reg, err_neg_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   div_start;
    logic [SPEED_W-1:0]     div_divisor;
    logic [SPEED_W-1:0]     div_quotient;
    div_stat_t              div_stat;

    logic                   hall_a1, hall_a2, adapt_req;
    logic                   load;
    logic [SPEED_W:0]       err;
    logic [SPEED_W:0]       mul_sum;
    logic [SPEED_W:0]       speed_sum;
    logic [PROD_W:0]        round_sum;
    logic [ND_W-1:0]        nd;
    logic [ND_W-1:0]        nd_ceil;
    logic [ND_W-1:0]        ceil_lim, floor_lim;
    logic [SPEED_W-1:0]     p1_out, p2_out;

    assign hall_a1   = s_axis_tdata[0];
    assign hall_a2   = s_axis_tdata[1];
    assign adapt_req = s_axis_tdata[2];

    hsda_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (speed_scale_reg),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        duty_next       = duty_reg;
        last_speed_next = last_speed_reg;
        valid_flag_next = valid_flag_reg;
        upd_flag_next   = upd_flag_reg;
        mul_cnt_next    = mul_cnt_reg;
        rise_a1_next    = rise_a1_reg;
        rise_b1_next    = rise_b1_reg;
        rise_a2_next    = rise_a2_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        speed1_next     = speed1_reg;
        mul_acc_next    = mul_acc_reg;
        mul_mag_next    = mul_mag_reg;
        err_neg_next    = err_neg_reg;
        div_start       = 1'b0;
        div_divisor     = 32'(p2_reg);
        load            = 1'b0;
        err             = {13'd0, target_speed_reg} - {1'b0, last_speed_reg};
        mul_sum         = {1'b0, mul_acc_reg[PROD_W-1:DUTY_W]}
                          + (mul_acc_reg[0] ? {1'b0, mul_mag_reg} : '0);
        speed_sum       = {1'b0, speed1_reg} + {1'b0, div_quotient};
        round_sum       = {1'b0, mul_acc_reg} + (PROD_W+1)'(16'hFFFF);
        ceil_lim        = ND_W'(lim_duty(duty_ceiling_reg));
        floor_lim       = ND_W'(lim_duty(duty_floor_reg));
        if (err_neg_reg)
        begin
            nd = ND_W'(duty_reg) - ND_W'(round_sum[PROD_W:16]);
        end
        else
        begin
            nd = ND_W'(duty_reg) + ND_W'(mul_acc_reg[PROD_W-1:16]);
        end
        nd_ceil = ($signed(nd) > $signed(ceil_lim)) ? ceil_lim : nd;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    valid_flag_next = 1'b0;
                    upd_flag_next   = 1'b0;
                    state_next      = S_LOAD;
                    unique case (phase_reg)
                        PH_WAIT_A1_LOW:
                        begin
                            if (!hall_a1)
                                phase_next = PH_RISE_A1;
                        end
                        PH_RISE_A1:
                        begin
                            if (hall_a1)
                            begin
                                rise_a1_next = elapsed_reg;
                                phase_next   = PH_RISE_B1;
                            end
                        end
                        PH_RISE_B1:
                        begin
                            if (hall_a2)
                            begin
                                rise_b1_next = elapsed_reg;
                                phase_next   = PH_WAIT_A2_LOW;
                            end
                        end
                        PH_WAIT_A2_LOW:
                        begin
                            if (!hall_a1)
                                phase_next = PH_WAIT_B2_LOW;
                        end
                        PH_WAIT_B2_LOW:
                        begin
                            if (!hall_a2)
                                phase_next = PH_RISE_A2;
                        end
                        PH_RISE_A2:
                        begin
                            if (hall_a1)
                            begin
                                rise_a2_next = elapsed_reg;
                                phase_next   = PH_RISE_B2;
                            end
                        end
                        PH_RISE_B2:
                        begin
                            if (hall_a2)
                            begin
                                p1_next         = rise_a2_reg - rise_a1_reg;
                                p2_next         = elapsed_reg - rise_b1_reg;
                                phase_next      = PH_WAIT_REQ;
                                valid_flag_next = 1'b1;
                                div_start       = 1'b1;
                                div_divisor     = 32'(p1_next);
                                state_next      = S_DIV1;
                            end
                        end
                        PH_WAIT_REQ:
                        begin
                            if (adapt_req)
                            begin
                                err_neg_next  = err[SPEED_W];
                                mul_mag_next  = err[SPEED_W] ? SPEED_W'(-err) : err[SPEED_W-1:0];
                                mul_acc_next  = PROD_W'(loop_gain_reg);
                                mul_cnt_next  = '0;
                                upd_flag_next = 1'b1;
                                elapsed_next  = '0;
                                phase_next    = PH_WAIT_A1_LOW;
                                state_next    = S_MUL;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                    if ((phase_reg != PH_WAIT_REQ) && (phase_next != PH_WAIT_REQ))
                        elapsed_next = elapsed_reg + 1'b1;
                end
            end
            S_DIV1:
            begin
                if (div_stat.done)
                begin
                    speed1_next = div_quotient;
                    div_start   = 1'b1;
                    state_next  = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_stat.done)
                begin
                    last_speed_next = speed_sum[SPEED_W:1];
                    state_next      = S_LOAD;
                end
            end
            S_MUL:
            begin
                mul_acc_next = {mul_sum, mul_acc_reg[DUTY_W-1:1]};
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == DIV_CNT_W'(DUTY_W - 1))
                    state_next = S_ADAPT;
            end
            S_ADAPT:
            begin
                // the floor wins when the limits cross
                if ($signed(nd_ceil) < $signed(floor_lim))
                    duty_next = floor_lim[DUTY_W-1:0];
                else
                    duty_next = nd_ceil[DUTY_W-1:0];
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign p1_out = valid_flag_reg ? 32'(p1_reg) : '0;
    assign p2_out = valid_flag_reg ? 32'(p2_reg) : '0;

    always_comb
    begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, phase_reg, p2_out, p1_out, last_speed_reg,
                             valid_flag_reg, upd_flag_reg, duty_reg};
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_WAIT_A1_LOW;
            elapsed_reg      <= '0;
            duty_reg         <= lim_duty(DUTY_START_RST);
            last_speed_reg   <= '0;
            valid_flag_reg   <= 1'b0;
            upd_flag_reg     <= 1'b0;
            mul_cnt_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
            speed_scale_reg  <= 32'd1081452145;
            target_speed_reg <= 20'd65536;
            loop_gain_reg    <= 17'd6554;
            duty_floor_reg   <= 17'd3277;
            duty_ceiling_reg <= 17'd65536;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            duty_reg       <= duty_next;
            last_speed_reg <= last_speed_next;
            valid_flag_reg <= valid_flag_next;
            upd_flag_reg   <= upd_flag_next;
            mul_cnt_reg    <= mul_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we)
            begin
                priority case (cfg_index)
                    REG_SPEED_SCALE:  speed_scale_reg  <= cfg_data;
                    REG_TARGET_SPEED: target_speed_reg <= cfg_data[TARGET_W-1:0];
                    REG_LOOP_GAIN:    loop_gain_reg    <= cfg_data[DUTY_W-1:0];
                    REG_DUTY_FLOOR:   duty_floor_reg   <= cfg_data[DUTY_W-1:0];
                    REG_DUTY_CEILING: duty_ceiling_reg <= cfg_data[DUTY_W-1:0];
                    default:          speed_scale_reg  <= speed_scale_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rise_a1_reg <= rise_a1_next;
        rise_b1_reg <= rise_b1_next;
        rise_a2_reg <= rise_a2_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        speed1_reg  <= speed1_next;
        mul_acc_reg <= mul_acc_next;
        mul_mag_reg <= mul_mag_next;
        err_neg_reg <= err_neg_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

// ===== sv/hsda_checker.sv =====
// port checker for the hall speed duty adapter, bound to the top level
module hsda_checker
    import hsda_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while previous one still in work");

    // a finished measurement leaves the sequencer waiting for adapt
    a_valid_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[18]) |-> (m_axis_tdata[117:115] == PH_WAIT_REQ))
        else $error("speed valid outside the adapt wait phase");

    // an update restarts the sequence and never coincides with a measurement
    a_update_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[17])
            |-> (m_axis_tdata[117:115] == PH_WAIT_A1_LOW) && !m_axis_tdata[18])
        else $error("duty update without sequence restart");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] <= FULL_DUTY))
        else $error("duty above full scale");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind hall_speed_duty_adapter_core hsda_checker u_hsda_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
